// ===== rtl/core/ncc_pkg.sv =====
package ncc_pkg;

	// field and accumulator widths
	localparam int PixW    = 8;
	localparam int CoordW  = 12;
	localparam int StepW   = 5;
	localparam int SumW    = 24;
	localparam int SqW     = 32;
	localparam int CountW  = 17;
	localparam int CfgW    = 32;
	localparam int CfgIdxW = 3;
	localparam int CorrW   = 16;

	// serial multiplier geometry
	localparam int MulAW   = 96;
	localparam int MulBW   = 48;
	localparam int MulPW   = 128;
	localparam int MulCntW = 6;

	// dot count ceiling
	localparam logic [CountW-1:0] MaxDots = 17'd65536;

	// configuration register indexes
	localparam logic [CfgIdxW-1:0] REG_STEP_X        = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_STEP_Y        = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_MASTER_SUM    = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_MASTER_SUM_SQ = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_DOT_COUNT     = 3'd4;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MOD,
		S_ACC,
		S_MUL,
		S_WAIT,
		S_SQ,
		S_OUT
	} state_t;

	// products run through the shared multiplier, in order
	typedef enum logic [3:0] {
		OP_ABN,
		OP_SATA,
		OP_SA2N,
		OP_SASA,
		OP_TA2N,
		OP_TATA,
		OP_NUMSQ,
		OP_DEN,
		OP_TEST
	} op_t;

endpackage

// ===== rtl/core/ncc_mul.sv =====
module ncc_mul (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [ncc_pkg::MulAW-1:0]  a,
	input  logic [ncc_pkg::MulBW-1:0]  b,
	output logic                       done,
	output logic [ncc_pkg::MulPW-1:0]  p
);
	import ncc_pkg::*;

	logic               busy_q;
	logic               done_q;
	logic [MulCntW-1:0] cnt_q;
	logic [MulPW-1:0]   a_q;
	logic [MulBW-1:0]   b_q;
	logic [MulPW-1:0]   p_q;

	// control: one multiplier bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= MulCntW'(MulBW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == MulCntW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift-add datapath, multiplier MSB first
	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= {{(MulPW-MulAW){1'b0}}, a};
			b_q <= b;
			p_q <= '0;
		end else if (busy_q) begin
			p_q <= {p_q[MulPW-2:0], 1'b0} + (b_q[MulBW-1] ? a_q : '0);
			b_q <= {b_q[MulBW-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign p    = p_q;

endmodule

// ===== rtl/core/subsampled_ncc_accumulator_core.sv =====
// channel  direction  handshake              payload
// in       input      in_valid / in_ready    master_pixel, target_pixel, row_y, col_index, last
// out      output     out_valid / out_ready  correlation
// cfg      input      cfg_we (no wait)       cfg_index, cfg_data
//
// A word passes through the row/column remainder units, is accumulated, and
// returns to idle. A last word adds the correlation: up to eight products
// on the shared shift-add multiplier, then 16 result-bit trials; a zero
// dot count or variance ends it early with zero. in_ready is low throughout.
// A finished result is held until out_ready; reset clears the sums and loads the default settings.
module subsampled_ncc_accumulator_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [ncc_pkg::PixW-1:0]         master_pixel,
	input  logic [ncc_pkg::PixW-1:0]         target_pixel,
	input  logic [ncc_pkg::CoordW-1:0]       row_y,
	input  logic [ncc_pkg::CoordW-1:0]       col_index,
	input  logic                             last,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [ncc_pkg::CorrW-1:0] correlation,
	input  logic                             cfg_we,
	input  logic [ncc_pkg::CfgIdxW-1:0]      cfg_index,
	input  logic [ncc_pkg::CfgW-1:0]         cfg_data
);
	import ncc_pkg::*;

	state_t state_q, state_d;
	op_t    op_q;

	// configuration
	logic [StepW-1:0]  step_x_q, step_y_q;
	logic [SumW-1:0]   master_sum_q;
	logic [SqW-1:0]    master_sum_sq_q;
	logic [CountW-1:0] dot_count_q;

	// accumulators
	logic [SumW-1:0] target_sum_q;
	logic [SqW-1:0]  target_sum_sq_q, cross_sum_q;

	// captured word
	logic [PixW-1:0]   mp_q, tp_q;
	logic [CoordW-1:0] row_q, col_q;
	logic              last_q;

	// remainder units
	logic [3:0]       mod_cnt_q;
	logic [StepW-1:0] rem_x_q, rem_y_q;
	logic [StepW-1:0] sx, sy;
	logic [StepW:0]   trial_x, trial_y;

	// correlation datapath
	logic [47:0]       t_q;
	logic [48:0]       num_q, fa_q, fb_q, fb_new;
	logic [MulPW-1:0]  lhs_q;
	logic [MulAW-1:0]  den_q;
	logic [31:0]       csq_q;
	logic [CorrW-1:0]  q_q, q_next, res_q, cand, lim, qmin;
	logic [3:0]        bit_q;
	logic [CountW-1:0] n_eff;
	logic [47:0]       abs_num, abs_fa, abs_fb;

	// multiplier hookup
	logic              mul_start, mul_done;
	logic [MulAW-1:0]  mul_a;
	logic [MulBW-1:0]  mul_b;
	logic [MulPW-1:0]  mul_p;

	ncc_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.p      (mul_p)
	);

	assign sx      = (step_x_q == '0) ? StepW'(1) : step_x_q;
	assign sy      = (step_y_q == '0) ? StepW'(1) : step_y_q;
	assign trial_x = {rem_x_q, col_q[CoordW-1]};
	assign trial_y = {rem_y_q, row_q[CoordW-1]};
	assign n_eff   = (dot_count_q > MaxDots) ? MaxDots : dot_count_q;

	assign abs_num = num_q[48] ? 48'(-num_q) : num_q[47:0];
	assign abs_fa  = fa_q[48] ? 48'(-fa_q) : fa_q[47:0];
	assign abs_fb  = fb_q[48] ? 48'(-fb_q) : fb_q[47:0];
	assign fb_new  = {1'b0, t_q} - {1'b0, mul_p[47:0]};
	assign cand    = q_q | (CorrW'(1) << bit_q);
	// trial bit kept when den * cand^2 still fits under num^2 * 2^30
	assign q_next  = (mul_p <= lhs_q) ? cand : q_q;
	assign lim     = num_q[48] ? 16'h8000 : 16'h7FFF;
	assign qmin    = (q_next > lim) ? lim : q_next;

	// operand select for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (op_q)
			OP_ABN:   begin mul_a = MulAW'(cross_sum_q);     mul_b = MulBW'(n_eff); end
			OP_SATA:  begin mul_a = MulAW'(master_sum_q);    mul_b = MulBW'(target_sum_q); end
			OP_SA2N:  begin mul_a = MulAW'(master_sum_sq_q); mul_b = MulBW'(n_eff); end
			OP_SASA:  begin mul_a = MulAW'(master_sum_q);    mul_b = MulBW'(master_sum_q); end
			OP_TA2N:  begin mul_a = MulAW'(target_sum_sq_q); mul_b = MulBW'(n_eff); end
			OP_TATA:  begin mul_a = MulAW'(target_sum_q);    mul_b = MulBW'(target_sum_q); end
			OP_NUMSQ: begin mul_a = MulAW'(abs_num);         mul_b = abs_num; end
			OP_DEN:   begin mul_a = MulAW'(abs_fa);          mul_b = abs_fb; end
			default:  begin mul_a = den_q;                   mul_b = MulBW'(csq_q); end
		endcase
	end

	// next state and handshake outputs
	always_comb begin
		state_d   = state_q;
		mul_start = 1'b0;
		unique case (state_q)
			S_IDLE: if (in_valid) state_d = S_MOD;
			S_MOD:  if (mod_cnt_q == '0) state_d = S_ACC;
			S_ACC: begin
				if (!last_q) state_d = S_IDLE;
				else if (n_eff == '0) state_d = S_OUT;
				else state_d = S_MUL;
			end
			S_MUL: begin
				mul_start = 1'b1;
				state_d   = S_WAIT;
			end
			S_WAIT: begin
				if (mul_done) begin
					case (op_q)
						OP_TATA: begin
							if (fa_q == '0 || fb_new == '0 || (fa_q[48] != fb_new[48]))
								state_d = S_OUT;
							else
								state_d = S_MUL;
						end
						OP_DEN:  state_d = S_SQ;
						OP_TEST: state_d = (bit_q == '0) ? S_OUT : S_SQ;
						default: state_d = S_MUL;
					endcase
				end
			end
			S_SQ:  state_d = S_MUL;
			S_OUT: if (out_ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = (state_q == S_OUT);
	assign correlation = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_x_q        <= StepW'(1);
			step_y_q        <= StepW'(1);
			master_sum_q    <= '0;
			master_sum_sq_q <= '0;
			dot_count_q     <= CountW'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_STEP_X:        step_x_q        <= cfg_data[StepW-1:0];
				REG_STEP_Y:        step_y_q        <= cfg_data[StepW-1:0];
				REG_MASTER_SUM:    master_sum_q    <= cfg_data[SumW-1:0];
				REG_MASTER_SUM_SQ: master_sum_sq_q <= cfg_data[SqW-1:0];
				REG_DOT_COUNT:     dot_count_q     <= cfg_data[CountW-1:0];
				default: ;
			endcase
		end
	end

	// sequencer control and accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q            <= OP_ABN;
			mod_cnt_q       <= '0;
			bit_q           <= '0;
			target_sum_q    <= '0;
			target_sum_sq_q <= '0;
			cross_sum_q     <= '0;
			res_q           <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: mod_cnt_q <= 4'(CoordW - 1);
				S_MOD:  mod_cnt_q <= mod_cnt_q - 1'b1;
				S_ACC: begin
					op_q  <= OP_ABN;
					res_q <= '0;
					if (rem_x_q == '0 && rem_y_q == '0) begin
						target_sum_q    <= target_sum_q + SumW'(tp_q);
						target_sum_sq_q <= target_sum_sq_q + SqW'(tp_q) * SqW'(tp_q);
						cross_sum_q     <= cross_sum_q + SqW'(mp_q) * SqW'(tp_q);
					end
				end
				S_WAIT: begin
					if (mul_done) begin
						case (op_q)
							OP_DEN:  bit_q <= 4'(CorrW - 1);
							OP_TEST: bit_q <= bit_q - 1'b1;
							default: ;
						endcase
						if (op_q != OP_TEST) op_q <= op_t'(op_q + 1'b1);
						if (op_q == OP_TEST && bit_q == '0)
							res_q <= num_q[48] ? CorrW'(-qmin) : qmin;
					end
				end
				S_OUT: begin
					if (out_ready) begin
						target_sum_q    <= '0;
						target_sum_sq_q <= '0;
						cross_sum_q     <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// word capture, remainder steps and correlation datapath
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			mp_q    <= master_pixel;
			tp_q    <= target_pixel;
			row_q   <= row_y;
			col_q   <= col_index;
			last_q  <= last;
			rem_x_q <= '0;
			rem_y_q <= '0;
		end
		// restoring remainder, one coordinate bit per cycle
		if (state_q == S_MOD) begin
			rem_x_q <= (trial_x >= {1'b0, sx}) ? StepW'(trial_x - {1'b0, sx}) : trial_x[StepW-1:0];
			rem_y_q <= (trial_y >= {1'b0, sy}) ? StepW'(trial_y - {1'b0, sy}) : trial_y[StepW-1:0];
			row_q   <= {row_q[CoordW-2:0], 1'b0};
			col_q   <= {col_q[CoordW-2:0], 1'b0};
		end
		if (state_q == S_ACC) q_q <= '0;
		// square of the trial quotient
		if (state_q == S_SQ) csq_q <= 32'(cand) * 32'(cand);
		if (state_q == S_WAIT && mul_done) begin
			case (op_q) inside
				OP_ABN, OP_SA2N, OP_TA2N: t_q <= mul_p[47:0];
				OP_SATA:  num_q <= {1'b0, t_q} - {1'b0, mul_p[47:0]};
				OP_SASA:  fa_q  <= {1'b0, t_q} - {1'b0, mul_p[47:0]};
				OP_TATA:  fb_q  <= fb_new;
				OP_NUMSQ: lhs_q <= {mul_p[MulPW-31:0], 30'b0};
				OP_DEN:   den_q <= mul_p[MulAW-1:0];
				default:  q_q <= q_next;
			endcase
		end
	end

endmodule

// ===== test/subsampled_ncc_accumulator_core_test.sv =====
`timescale 1ns / 100ps

module subsampled_ncc_accumulator_core_test;
	import ncc_pkg::*;

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_ready;
	logic [PixW-1:0]         master_pixel;
	logic [PixW-1:0]         target_pixel;
	logic [CoordW-1:0]       row_y;
	logic [CoordW-1:0]       col_index;
	logic                    last;
	logic                    out_valid;
	logic                    out_ready;
	logic signed [CorrW-1:0] correlation;
	logic                    cfg_we;
	logic [CfgIdxW-1:0]      cfg_index;
	logic [CfgW-1:0]         cfg_data;

	subsampled_ncc_accumulator_core u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.master_pixel(master_pixel), .target_pixel(target_pixel),
		.row_y(row_y), .col_index(col_index), .last(last),
		.out_valid(out_valid), .out_ready(out_ready), .correlation(correlation),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// mirror of the block's registers and sums
	logic [StepW-1:0]  step_x_m, step_y_m;
	logic [SumW-1:0]   m_sum, t_sum;
	logic [SqW-1:0]    m_sq, t_sq, x_sum;
	logic [CountW-1:0] dots;

	logic [CorrW-1:0] corr_q[$];
	int               errors, words_sent, corr_checked, cfg_writes;
	int               snd_idle, rcv_stall;
	bit               hold_req;
	int               hold_left;

	typedef struct {
		bit                cfg;
		logic [CfgIdxW-1:0] idx;
		logic [CfgW-1:0]   data;
		logic [7:0]        mp, tp;
		logic [11:0]       row, col;
		bit                lst, typed;
		logic [CorrW-1:0]  exp_corr;
	} dir_row_t;

	dir_row_t dir_tbl[$];

	// clock
	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// run limit
	initial begin
		#100ms;
		$display("subsampled_ncc_accumulator_core: mismatch");
		$finish;
	end

	// exact Pearson correlation in Q1.15 from the mirrored sums
	function automatic logic [CorrW-1:0] ncc_of_sums();
		logic signed [63:0] n, sa, ta, num, fa, fb;
		logic [63:0]        anum, afa, afb, lo, hi, mid, lim;
		logic [191:0]       lhs, base, prod;
		n = (dots > MaxDots) ? 64'sd65536 : $signed({47'd0, dots});
		if (n == 0)
			return '0;
		sa  = $signed({40'd0, m_sum});
		ta  = $signed({40'd0, t_sum});
		num = $signed({32'd0, x_sum}) * n - sa * ta;
		fa  = $signed({32'd0, m_sq}) * n - sa * sa;
		fb  = $signed({32'd0, t_sq}) * n - ta * ta;
		if (fa == 0 || fb == 0 || ((fa < 0) != (fb < 0)))
			return '0;
		anum = num < 0 ? -num : num;
		afa  = fa < 0 ? -fa : fa;
		afb  = fb < 0 ? -fb : fb;
		lhs  = 192'(anum);
		lhs  = lhs * 192'(anum);
		lhs  = lhs << 30;
		base = 192'(afa) * 192'(afb);
		lim  = num < 0 ? 64'd32768 : 64'd32767;
		lo   = 0;
		hi   = lim;
		// largest q with den*q^2 <= num^2 * 2^30
		while (lo < hi) begin
			mid  = (lo + hi + 1) >> 1;
			prod = base * 192'(mid * mid);
			if (prod <= lhs)
				lo = mid;
			else
				hi = mid - 1;
		end
		return num < 0 ? 16'(17'h10000 - lo[16:0]) : lo[15:0];
	endfunction

	// word accepted: accumulate, and on last predict and clear
	function automatic void take_word(logic [7:0] mp, logic [7:0] tp, logic [11:0] row,
			logic [11:0] col, bit lst, bit typed, logic [CorrW-1:0] typed_corr);
		logic [11:0] sx, sy;
		sx = step_x_m == 0 ? 12'd1 : 12'(step_x_m);
		sy = step_y_m == 0 ? 12'd1 : 12'(step_y_m);
		if (row % sy == 0 && col % sx == 0) begin
			t_sum = t_sum + 24'(tp);
			t_sq  = t_sq + 32'(tp) * 32'(tp);
			x_sum = x_sum + 32'(mp) * 32'(tp);
		end
		if (lst) begin
			corr_q.push_back(typed ? typed_corr : ncc_of_sums());
			t_sum = '0;
			t_sq  = '0;
			x_sum = '0;
		end
	endfunction

	// drive one word; entered and left at a falling edge
	task automatic send_word(logic [7:0] mp, logic [7:0] tp, logic [11:0] row,
			logic [11:0] col, bit lst, bit typed = 0, logic [CorrW-1:0] typed_corr = '0);
		while ($urandom_range(99) < snd_idle) begin
			in_valid = 0;
			@(negedge clk);
		end
		in_valid     = 1;
		master_pixel = mp;
		target_pixel = tp;
		row_y        = row;
		col_index    = col;
		last         = lst;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		take_word(mp, tp, row, col, lst, typed, typed_corr);
		words_sent++;
		@(negedge clk);
		in_valid = 0;
	endtask

	// hold the sender until every correlation is out, then let the block settle
	task automatic drain();
		in_valid = 0;
		while (corr_q.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
		case (idx)
			REG_STEP_X:        step_x_m = data[StepW-1:0];
			REG_STEP_Y:        step_y_m = data[StepW-1:0];
			REG_MASTER_SUM:    m_sum    = data[SumW-1:0];
			REG_MASTER_SUM_SQ: m_sq     = data[SqW-1:0];
			REG_DOT_COUNT:     dots     = data[CountW-1:0];
			default: ;
		endcase
		cfg_we    = 1;
		cfg_index = idx;
		cfg_data  = data;
		@(negedge clk);
		cfg_we = 0;
		cfg_writes++;
	endtask

	function automatic void add_cfg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
		dir_row_t r;
		r = '{default: '0};
		r.cfg  = 1;
		r.idx  = idx;
		r.data = data;
		dir_tbl.push_back(r);
	endfunction

	function automatic void add_word(logic [7:0] mp, logic [7:0] tp, logic [11:0] row,
			logic [11:0] col, bit lst, bit typed = 0, logic [CorrW-1:0] ec = '0);
		dir_row_t r;
		r = '{default: '0};
		r.mp = mp; r.tp = tp; r.row = row; r.col = col; r.lst = lst;
		r.typed = typed; r.exp_corr = ec;
		dir_tbl.push_back(r);
	endfunction

	// one area whose master sums are written to match its own sampled pixels
	task automatic matched_area();
		int          w, h, mode, n_used;
		logic [11:0] row0, sx, sy;
		logic [7:0]  mps[$], tps[$];
		logic [11:0] rows[$], cols[$];
		logic [31:0] sa, sa2;
		logic [4:0]  stx, sty;
		logic [7:0]  mp, tp;
		w    = $urandom_range(12, 1);
		h    = $urandom_range(4, 1);
		row0 = 12'($urandom_range(4095 - h));
		mode = $urandom_range(4);
		stx  = $urandom_range(9) == 0 ? 5'($urandom_range(31)) : 5'($urandom_range(4, 1));
		sty  = $urandom_range(9) == 0 ? 5'($urandom_range(31)) : 5'($urandom_range(3, 1));
		sx   = stx == 0 ? 12'd1 : 12'(stx);
		sy   = sty == 0 ? 12'd1 : 12'(sty);
		sa   = 0;
		sa2  = 0;
		n_used = 0;
		for (int r = 0; r < h; r++) begin
			for (int c = 0; c < w; c++) begin
				mp = 8'($urandom_range(255));
				case (mode)
					0: tp = mp;
					1: tp = 8'd255 - mp;
					2: tp = (mp >> 1) + 8'($urandom_range(31));
					3: tp = 8'($urandom_range(255));
					default: tp = 8'd200 - (mp >> 2) + 8'($urandom_range(3));
				endcase
				mps.push_back(mp);
				tps.push_back(tp);
				rows.push_back(row0 + 12'(r));
				cols.push_back(12'(c));
				if ((row0 + 12'(r)) % sy == 0 && 12'(c) % sx == 0) begin
					sa  += mp;
					sa2 += mp * mp;
					n_used++;
				end
			end
		end
		drain();
		cfg_write(REG_STEP_X, 32'(stx));
		cfg_write(REG_STEP_Y, 32'(sty));
		cfg_write(REG_MASTER_SUM, sa);
		cfg_write(REG_MASTER_SUM_SQ, sa2);
		// now and then a dot count that disagrees with the area
		cfg_write(REG_DOT_COUNT, $urandom_range(7) == 0 ? 32'($urandom_range(40))
			: 32'(n_used));
		for (int i = 0; i < mps.size(); i++)
			send_word(mps[i], tps[i], rows[i], cols[i], i == mps.size() - 1);
	endtask

	// free-running area under the current settings, with some fully random words
	task automatic loose_area();
		int n;
		n = $urandom_range(20, 1);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(4) == 0)
				send_word(8'($urandom_range(255)), 8'($urandom_range(255)),
					12'($urandom_range(4095)), 12'($urandom_range(4095)), i == n - 1);
			else
				send_word(8'($urandom_range(255)), 8'($urandom_range(255)),
					12'($urandom_range(3)), 12'(i), i == n - 1);
		end
	endtask

	function automatic logic [CfgW-1:0] pick(logic [CfgW-1:0] lo_v, logic [CfgW-1:0] hi_v);
		case ($urandom_range(3))
			0: return lo_v;
			1: return hi_v;
			default: begin
				// a full 32-bit span has no representable modulus
				if (hi_v - lo_v == '1)
					return $urandom();
				return lo_v + ($urandom() % (hi_v - lo_v + 1));
			end
		endcase
	endfunction

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (corr_q.size() == 0) begin
				$error("correlation: expected none, got %0d", correlation);
				errors++;
			end else begin
				if (correlation !== corr_q[0]) begin
					$error("correlation: expected %0d, got %0d", $signed(corr_q[0]),
						correlation);
					errors++;
				end
				void'(corr_q.pop_front());
				corr_checked++;
			end
		end
	end

	// receiver: random stalls, plus a long hold-off on request
	initial begin
		out_ready = 0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_left = 3000;
				hold_req  = 0;
			end
			if (hold_left > 0) begin
				out_ready = 0;
				hold_left--;
			end else
				out_ready = $urandom_range(99) >= rcv_stall;
		end
	end

	initial begin
		int batch;
		in_valid = 0; master_pixel = 0; target_pixel = 0; row_y = 0; col_index = 0;
		last = 0; cfg_we = 0; cfg_index = '0; cfg_data = '0;
		snd_idle = 0; rcv_stall = 0; hold_req = 0;
		errors = 0; words_sent = 0; corr_checked = 0; cfg_writes = 0;
		step_x_m = 1; step_y_m = 1; m_sum = 0; m_sq = 0; dots = 1;
		t_sum = 0; t_sq = 0; x_sum = 0;
		arst_n = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: reset settings give zero master variance, so zero
		add_word(8'd0, 8'd0, 12'd0, 12'd0, 1, 1, 16'd0);
		add_word(8'd255, 8'd255, 12'd4095, 12'd4095, 0);
		add_word(8'd170, 8'd85, 12'hAAA, 12'h555, 0);
		add_word(8'd85, 8'd170, 12'h555, 12'hAAA, 1, 1, 16'd0);
		// zero steps keep everything; ratio above one saturates high
		add_cfg(REG_STEP_X, 32'd0);
		add_cfg(REG_STEP_Y, 32'd0);
		add_cfg(REG_MASTER_SUM, 32'd0);
		add_cfg(REG_MASTER_SUM_SQ, 32'd1);
		add_cfg(REG_DOT_COUNT, 32'd2);
		add_word(8'd255, 8'd1, 12'd0, 12'd0, 0);
		add_word(8'd0, 8'd0, 12'd3, 12'd7, 1, 1, 16'h7FFF);
		// exact anti-correlation hits the negative limit
		add_cfg(REG_MASTER_SUM, 32'd255);
		add_cfg(REG_MASTER_SUM_SQ, 32'd65025);
		add_word(8'd0, 8'd1, 12'd0, 12'd0, 0);
		add_word(8'd0, 8'd0, 12'd1, 12'd1, 1, 1, 16'h8000);
		// zero dot count
		add_cfg(REG_DOT_COUNT, 32'd0);
		add_word(8'd12, 8'd34, 12'd5, 12'd6, 1, 1, 16'd0);
		// dot count above the ceiling, large steps and widest sums
		add_cfg(REG_DOT_COUNT, 32'h1FFFF);
		add_cfg(REG_STEP_X, 32'd16);
		add_cfg(REG_STEP_Y, 32'd31);
		add_cfg(REG_MASTER_SUM, 32'hFFFFFF);
		add_cfg(REG_MASTER_SUM_SQ, 32'hFFFFFFFF);
		add_word(8'd255, 8'd255, 12'd0, 12'd0, 0);
		add_word(8'd1, 8'd200, 12'd31, 12'd16, 0);
		add_word(8'd9, 8'd0, 12'd62, 12'd15, 0);
		add_word(8'd77, 8'd3, 12'd4092, 12'd4080, 1);
		// plain subsampling with a last pair that is skipped
		add_cfg(REG_STEP_X, 32'd3);
		add_cfg(REG_STEP_Y, 32'd2);
		add_cfg(REG_MASTER_SUM, 32'd300);
		add_cfg(REG_MASTER_SUM_SQ, 32'd50000);
		add_cfg(REG_DOT_COUNT, 32'd3);
		add_word(8'd100, 8'd90, 12'd0, 12'd0, 0);
		add_word(8'd120, 8'd110, 12'd0, 12'd3, 0);
		add_word(8'd80, 8'd60, 12'd2, 12'd6, 0);
		add_word(8'd50, 8'd250, 12'd2, 12'd7, 1);

		foreach (dir_tbl[i]) begin
			if (dir_tbl[i].cfg) begin
				drain();
				cfg_write(dir_tbl[i].idx, dir_tbl[i].data);
			end else
				send_word(dir_tbl[i].mp, dir_tbl[i].tp, dir_tbl[i].row, dir_tbl[i].col,
					dir_tbl[i].lst, dir_tbl[i].typed, dir_tbl[i].exp_corr);
		end

		// random: idling phase per batch, matched areas mixed with random settings
		batch = 0;
		while (words_sent < 1450) begin
			case (batch % 4)
				0: begin snd_idle = 0;  rcv_stall = 0;  end
				1: begin snd_idle = 60; rcv_stall = 0;  end
				2: begin snd_idle = 0;  rcv_stall = 60; end
				default: begin snd_idle = 26; rcv_stall = 26; end
			endcase
			if (batch % 3 == 2) begin
				drain();
				cfg_write(REG_STEP_X, pick(0, 31));
				cfg_write(REG_STEP_Y, pick(0, 31));
				cfg_write(REG_MASTER_SUM, pick(0, 32'hFFFFFF));
				cfg_write(REG_MASTER_SUM_SQ, pick(0, 32'hFFFFFFFF));
				cfg_write(REG_DOT_COUNT, pick(0, 32'h1FFFF));
				// long receiver hold-off while areas keep coming
				if (batch == 5)
					hold_req = 1;
				repeat (4) loose_area();
			end else begin
				repeat (6) matched_area();
			end
			batch++;
		end

		drain();
		$display("%0d words in %0d batches, %0d correlations checked, %0d register writes",
			words_sent, batch, corr_checked, cfg_writes);
		if (errors == 0)
			$display("subsampled_ncc_accumulator_core: match");
		else
			$display("subsampled_ncc_accumulator_core: mismatch");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/ncc_pkg.sv
rtl/core/ncc_mul.sv
rtl/core/subsampled_ncc_accumulator_core.sv
test/subsampled_ncc_accumulator_core_test.sv
